// File: hw/rtl/dll_pkg.sv
// Shared types, codes and defaults for the doubly linked list engine.
package dll_pkg;

  localparam int DEPTH_DEF       = 32;
  localparam int VALUE_WIDTH_DEF = 32;

  typedef enum logic [2:0] {
    REQ_INS_FRONT = 3'd0,
    REQ_INS_BACK  = 3'd1,
    REQ_INS_AT    = 3'd2,
    REQ_DEL_FRONT = 3'd3,
    REQ_DEL_BACK  = 3'd4,
    REQ_DEL_AT    = 3'd5,
    REQ_DUMP      = 3'd6,
    REQ_NONE      = 3'd7
  } req_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_INVALID = 2'd2,
    ST_FULL    = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FREE,
    S_FREE_D,
    S_SEEK,
    S_WALK,
    S_W1,
    S_W2
  } state_t;

  // Splice kind chosen when the transaction is accepted.
  typedef enum logic [2:0] {
    M_FRONT,
    M_BACK,
    M_MID,
    M_ONLY,
    M_FIRST,
    M_LAST
  } mode_t;

  typedef struct packed {
    logic [2:0]         req_type;
    logic signed [31:0] value;
    logic [5:0]         position;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] item_value;
    logic               last_item;
  } out_item_t;

endpackage

// File: hw/rtl/dll_store.sv
// Node store: value, next-link and prev-link memories with registered reads.
module dll_store import dll_pkg::*; #(
  parameter int DEPTH       = DEPTH_DEF,
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
  localparam int AW         = $clog2(DEPTH)
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [AW-1:0]          rd_addr,
  output logic [VALUE_WIDTH-1:0] rd_val,
  output logic [AW-1:0]          rd_nxt,
  output logic [AW-1:0]          rd_prv,
  input  logic                   val_we,
  input  logic [AW-1:0]          val_addr,
  input  logic [VALUE_WIDTH-1:0] val_data,
  input  logic                   nxt_we,
  input  logic [AW-1:0]          nxt_addr,
  input  logic [AW-1:0]          nxt_data,
  input  logic                   prv_we,
  input  logic [AW-1:0]          prv_addr,
  input  logic [AW-1:0]          prv_data
);

  logic [VALUE_WIDTH-1:0] val_mem [DEPTH];
  logic [AW-1:0]          nxt_mem [DEPTH];
  logic [AW-1:0]          prv_mem [DEPTH];
  logic [DEPTH-1:0]       nxt_vld_r;

  // An unwritten next link still holds its place in the initial free chain.
  function automatic logic [AW-1:0] chain_next(input logic [AW-1:0] a);
    return (a == AW'(DEPTH - 1)) ? '0 : a + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nxt_vld_r <= '0;
    end else if (nxt_we) begin
      nxt_vld_r[nxt_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (val_we) begin
      val_mem[val_addr] <= val_data;
    end
    if (nxt_we) begin
      nxt_mem[nxt_addr] <= nxt_data;
    end
    if (prv_we) begin
      prv_mem[prv_addr] <= prv_data;
    end
    rd_val <= val_mem[rd_addr];
    rd_prv <= prv_mem[rd_addr];
    rd_nxt <= nxt_vld_r[rd_addr] ? nxt_mem[rd_addr] : chain_next(rd_addr);
  end

endmodule

// File: hw/rtl/doubly_linked_list_engine_unit.sv
// Top level of the doubly linked list engine: request sequencer over the node store.
//
//  channel  ports                         direction  transfer rule
//  request  start, busy, in_item          in         taken when start && !busy
//  result   out_valid, out_item           out        one cycle per result, no stall
//
// An insert at the front or back steps through S_FREE, S_FREE_D, S_W1 and
// S_W2; a failed request answers in the cycle after it is taken and frees the
// engine at once. Positional operations and the dump walk the list one node
// per cycle through the single read port of the node store, so the engine
// stays busy until the walk and any write-back after it are done, and only
// then takes the next request. A dump gives one result per cycle while it
// walks. Reset (rst_n, synchronous) empties the list and rebuilds the free
// chain through per-entry valid bits on the next links. The receiver cannot
// stall: every result is shown for exactly one cycle and must be taken.
module doubly_linked_list_engine_unit import dll_pkg::*; #(
  parameter int DEPTH       = DEPTH_DEF,
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_item,
  output logic      out_valid,
  output out_item_t out_item
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  // Wide enough to compare a 6-bit position against count + 1.
  localparam int EW = ((CW > 6) ? CW : 6) + 1;

  // Sequencer state.
  state_t                 state_r, state_nxt;
  req_t                   req_r, req_nxt;
  mode_t                  mode_r, mode_nxt;
  logic [VALUE_WIDTH-1:0] v_r, v_nxt;
  logic [CW-1:0]          steps_r, steps_nxt;
  logic [AW-1:0]          cur_r, cur_nxt;

  // List bookkeeping.
  logic [AW-1:0]          head_r, head_nxt;
  logic [AW-1:0]          tail_r, tail_nxt;
  logic [CW-1:0]          count_r, count_nxt;
  logic [AW-1:0]          free_r, free_nxt;
  logic [AW-1:0]          fnext_r, fnext_nxt;

  // Fields of the node the walk stopped on.
  logic [AW-1:0]          node_r, node_nxt;
  logic [AW-1:0]          nn_r, nn_nxt;
  logic [AW-1:0]          np_r, np_nxt;
  logic [VALUE_WIDTH-1:0] nv_r, nv_nxt;

  logic                   out_valid_r, out_valid_nxt;
  out_item_t              out_item_r, out_item_nxt;

  // Store ports.
  logic [AW-1:0]          rd_addr;
  logic [VALUE_WIDTH-1:0] rd_val;
  logic [AW-1:0]          rd_nxt, rd_prv;
  logic                   val_we, nxt_we, prv_we;
  logic [AW-1:0]          val_addr, nxt_addr, prv_addr;
  logic [VALUE_WIDTH-1:0] val_data;
  logic [AW-1:0]          nxt_data, prv_data;

  // Decision taken on an accepted request.
  logic                   accept;
  logic                   dec_fail;
  status_t                dec_status;
  state_t                 dec_state;
  mode_t                  dec_mode;
  logic [AW-1:0]          dec_cur;
  logic [CW-1:0]          dec_steps;
  logic                   is_ins;
  logic                   empty, full;
  logic [EW-1:0]          pos_e, cnt_e;
  logic [VALUE_WIDTH-1:0] in_val;

  dll_store #(
    .DEPTH       (DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_addr  (rd_addr),
    .rd_val   (rd_val),
    .rd_nxt   (rd_nxt),
    .rd_prv   (rd_prv),
    .val_we   (val_we),
    .val_addr (val_addr),
    .val_data (val_data),
    .nxt_we   (nxt_we),
    .nxt_addr (nxt_addr),
    .nxt_data (nxt_data),
    .prv_we   (prv_we),
    .prv_addr (prv_addr),
    .prv_data (prv_data)
  );

  assign busy      = (state_r != S_IDLE);
  assign accept    = start && !busy;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  assign empty  = (count_r == '0);
  assign full   = (count_r == CW'(DEPTH));
  assign pos_e  = EW'(in_item.position);
  assign cnt_e  = EW'(count_r);
  assign is_ins = (req_r == REQ_INS_FRONT) || (req_r == REQ_INS_BACK) ||
                  (req_r == REQ_INS_AT);
  // Stored values keep the low bits of the sign-extended input.
  assign in_val = VALUE_WIDTH'($signed(in_item.value));

  // Classify a new request: error status, or where the sequencer starts.
  always_comb begin
    dec_fail   = 1'b0;
    dec_status = ST_OK;
    dec_state  = S_IDLE;
    dec_mode   = M_FRONT;
    dec_cur    = head_r;
    dec_steps  = '0;
    case (req_t'(in_item.req_type))
      REQ_INS_FRONT, REQ_INS_BACK: begin
        if (full) begin
          dec_fail   = 1'b1;
          dec_status = ST_FULL;
        end else begin
          dec_state = S_FREE;
          dec_mode  = (in_item.req_type == REQ_INS_FRONT) ? M_FRONT : M_BACK;
        end
      end
      REQ_INS_AT: begin
        if (pos_e == '0 || pos_e > cnt_e + 1'b1) begin
          dec_fail   = 1'b1;
          dec_status = ST_INVALID;
        end else if (full) begin
          dec_fail   = 1'b1;
          dec_status = ST_FULL;
        end else begin
          dec_state = S_FREE;
          if (pos_e == EW'(1)) begin
            dec_mode = M_FRONT;
          end else if (pos_e == cnt_e + 1'b1) begin
            dec_mode = M_BACK;
          end else begin
            dec_mode  = M_MID;
            dec_steps = CW'(pos_e - EW'(2));
          end
        end
      end
      REQ_DEL_FRONT, REQ_DEL_BACK, REQ_DEL_AT: begin
        if (empty) begin
          dec_fail   = 1'b1;
          dec_status = ST_EMPTY;
        end else if (in_item.req_type == REQ_DEL_AT &&
                     (pos_e == '0 || pos_e > cnt_e)) begin
          dec_fail   = 1'b1;
          dec_status = ST_INVALID;
        end else begin
          dec_state = S_SEEK;
          if (in_item.req_type == REQ_DEL_BACK) begin
            dec_cur = tail_r;
          end else if (in_item.req_type == REQ_DEL_AT) begin
            dec_steps = CW'(pos_e - EW'(1));
          end
          if (count_r == CW'(1)) begin
            dec_mode = M_ONLY;
          end else if (in_item.req_type == REQ_DEL_FRONT ||
                       (in_item.req_type == REQ_DEL_AT && pos_e == EW'(1))) begin
            dec_mode = M_FIRST;
          end else if (in_item.req_type == REQ_DEL_BACK ||
                       (in_item.req_type == REQ_DEL_AT && pos_e == cnt_e)) begin
            dec_mode = M_LAST;
          end else begin
            dec_mode = M_MID;
          end
        end
      end
      REQ_DUMP: begin
        if (empty) begin
          dec_fail   = 1'b1;
          dec_status = ST_EMPTY;
        end else begin
          dec_state = S_SEEK;
          dec_steps = count_r - 1'b1;
        end
      end
      default: begin
        dec_state = S_IDLE;
      end
    endcase
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:   state_nxt = accept ? dec_state : S_IDLE;
      S_FREE:   state_nxt = S_FREE_D;
      S_FREE_D: state_nxt = (mode_r == M_MID) ? S_SEEK : S_W1;
      S_SEEK:   state_nxt = S_WALK;
      S_WALK: begin
        if (steps_r == '0) begin
          state_nxt = (req_r == REQ_DUMP) ? S_IDLE : (is_ins ? S_FREE_D : S_W1);
          if (is_ins) begin
            state_nxt = S_W1;
          end
        end
      end
      S_W1:     state_nxt = S_W2;
      S_W2:     state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // Datapath, store accesses and results.
  always_comb begin
    req_nxt       = req_r;
    mode_nxt      = mode_r;
    v_nxt         = v_r;
    steps_nxt     = steps_r;
    cur_nxt       = cur_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    count_nxt     = count_r;
    free_nxt      = free_r;
    fnext_nxt     = fnext_r;
    node_nxt      = node_r;
    nn_nxt        = nn_r;
    np_nxt        = np_r;
    nv_nxt        = nv_r;
    out_valid_nxt = 1'b0;
    out_item_nxt  = out_item_r;
    rd_addr       = cur_r;
    val_we        = 1'b0;
    val_addr      = free_r;
    val_data      = v_r;
    nxt_we        = 1'b0;
    nxt_addr      = free_r;
    nxt_data      = head_r;
    prv_we        = 1'b0;
    prv_addr      = free_r;
    prv_data      = free_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          req_nxt   = req_t'(in_item.req_type);
          mode_nxt  = dec_mode;
          v_nxt     = in_val;
          cur_nxt   = dec_cur;
          steps_nxt = dec_steps;
          if (dec_fail) begin
            out_valid_nxt = 1'b1;
            out_item_nxt  = '{status: dec_status, item_value: '0, last_item: 1'b1};
          end
        end
      end
      S_FREE: begin
        rd_addr = free_r;
      end
      S_FREE_D: begin
        fnext_nxt = rd_nxt;
        cur_nxt   = head_r;
      end
      S_SEEK: begin
        rd_addr = cur_r;
      end
      S_WALK: begin
        // Read data holds the fields of node cur_r.
        if (req_r == REQ_DUMP) begin
          out_valid_nxt = 1'b1;
          out_item_nxt  = '{status: ST_OK, item_value: 32'(rd_val),
                            last_item: (steps_r == '0)};
        end
        if (steps_r == '0) begin
          node_nxt = cur_r;
          nn_nxt   = rd_nxt;
          np_nxt   = rd_prv;
          nv_nxt   = rd_val;
        end else begin
          rd_addr   = rd_nxt;
          cur_nxt   = rd_nxt;
          steps_nxt = steps_r - 1'b1;
        end
      end
      S_W1: begin
        if (is_ins) begin
          val_we = 1'b1;
          case (mode_r)
            M_FRONT: begin
              prv_we   = 1'b1;
              nxt_we   = !empty;
              nxt_data = head_r;
            end
            M_BACK: begin
              prv_we   = 1'b1;
              prv_data = empty ? free_r : tail_r;
              nxt_we   = !empty;
              nxt_addr = tail_r;
              nxt_data = free_r;
            end
            default: begin
              nxt_we   = 1'b1;
              nxt_data = nn_r;
              prv_we   = 1'b1;
              prv_data = node_r;
            end
          endcase
        end else if (mode_r == M_MID) begin
          // Unlink the middle node from both neighbors.
          nxt_we   = 1'b1;
          nxt_addr = np_r;
          nxt_data = nn_r;
          prv_we   = 1'b1;
          prv_addr = nn_r;
          prv_data = np_r;
        end
      end
      S_W2: begin
        out_valid_nxt = 1'b1;
        if (is_ins) begin
          out_item_nxt = '{status: ST_OK, item_value: '0, last_item: 1'b1};
          count_nxt    = count_r + 1'b1;
          free_nxt     = fnext_r;
          case (mode_r)
            M_FRONT: begin
              prv_we   = !empty;
              prv_addr = head_r;
              head_nxt = free_r;
              if (empty) begin
                tail_nxt = free_r;
              end
            end
            M_BACK: begin
              tail_nxt = free_r;
              if (empty) begin
                head_nxt = free_r;
              end
            end
            default: begin
              nxt_we   = 1'b1;
              nxt_addr = node_r;
              nxt_data = free_r;
              prv_we   = 1'b1;
              prv_addr = nn_r;
            end
          endcase
        end else begin
          // Return the removed node to the front of the free chain.
          out_item_nxt = '{status: ST_OK, item_value: 32'(nv_r), last_item: 1'b1};
          nxt_we       = 1'b1;
          nxt_addr     = node_r;
          nxt_data     = free_r;
          free_nxt     = node_r;
          count_nxt    = count_r - 1'b1;
          case (mode_r)
            M_ONLY: begin
              head_nxt = '0;
              tail_nxt = '0;
            end
            M_FIRST: head_nxt = nn_r;
            M_LAST:  tail_nxt = np_r;
            default: head_nxt = head_r;
          endcase
        end
      end
      default: begin
        rd_addr = cur_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      free_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      count_r     <= count_nxt;
      free_r      <= free_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r      <= req_nxt;
    mode_r     <= mode_nxt;
    v_r        <= v_nxt;
    steps_r    <= steps_nxt;
    cur_r      <= cur_nxt;
    fnext_r    <= fnext_nxt;
    node_r     <= node_nxt;
    nn_r       <= nn_nxt;
    np_r       <= np_nxt;
    nv_r       <= nv_nxt;
    out_item_r <= out_item_nxt;
  end

  // The list never holds more nodes than the store has.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("entry count exceeds store depth");

  // The write-back pair always closes the transaction with one result.
  a_w2_result: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_W2 |=> out_valid && !busy && out_item.last_item)
    else $error("write-back did not end the transaction");

  // A refused request leaves the list untouched.
  a_fail_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.status != ST_OK |-> $stable(count_r) && $stable(free_r))
    else $error("failed request changed the list");

  // Inserts and deletes change the count only when their result is issued.
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_W2 |=> $stable(count_r))
    else $error("entry count moved outside write-back");

endmodule

// File: test/tb_doubly_linked_list_engine_unit.sv
// Testbench for the doubly linked list engine: random and directed requests checked against a predictor.
`timescale 1ns / 1ps

module tb_doubly_linked_list_engine_unit;
  import dll_pkg::*;

  localparam int NODES = DEPTH_DEF;
  localparam int CYCLE_LIMIT = 400000;

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  in_item_t  in_item;
  logic      out_valid;
  out_item_t out_item;

  doubly_linked_list_engine_unit i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item)
  );

  // The predictor keeps the list as a plain queue of values, head first.
  // Node indexes inside the engine do not show on the outputs, so only the
  // order of the values matters.
  logic signed [31:0] list_values[$];
  out_item_t          expected_results[$];
  in_item_t           pending_requests[$];

  int  mismatch_count;
  int  cycle_count;
  bit  stimulus_done;
  int  gap_left;
  int  burst_left;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic out_item_t make_result(status_t st, logic signed [31:0] v, logic last);
    out_item_t r;
    r.status     = st;
    r.item_value = v;
    r.last_item  = last;
    return r;
  endfunction

  // Works out the results of one accepted transaction and updates the list.
  task automatic predict_request(input in_item_t req);
    int cnt;
    int pos;
    cnt = list_values.size();
    pos = req.position;
    case (req_t'(req.req_type))
      REQ_INS_FRONT, REQ_INS_BACK: begin
        if (cnt >= NODES) begin
          expected_results.push_back(make_result(ST_FULL, '0, 1'b1));
        end else begin
          if (req.req_type == REQ_INS_FRONT) list_values.push_front(req.value);
          else list_values.push_back(req.value);
          expected_results.push_back(make_result(ST_OK, '0, 1'b1));
        end
      end
      REQ_INS_AT: begin
        // The position is checked before the store is checked for room.
        if (pos < 1 || pos > cnt + 1) begin
          expected_results.push_back(make_result(ST_INVALID, '0, 1'b1));
        end else if (cnt >= NODES) begin
          expected_results.push_back(make_result(ST_FULL, '0, 1'b1));
        end else begin
          list_values.insert(pos - 1, req.value);
          expected_results.push_back(make_result(ST_OK, '0, 1'b1));
        end
      end
      REQ_DEL_FRONT, REQ_DEL_BACK, REQ_DEL_AT: begin
        if (cnt == 0) begin
          expected_results.push_back(make_result(ST_EMPTY, '0, 1'b1));
        end else begin
          if (req.req_type == REQ_DEL_FRONT) pos = 1;
          else if (req.req_type == REQ_DEL_BACK) pos = cnt;
          if (pos < 1 || pos > cnt) begin
            expected_results.push_back(make_result(ST_INVALID, '0, 1'b1));
          end else begin
            expected_results.push_back(make_result(ST_OK, list_values[pos - 1], 1'b1));
            list_values.delete(pos - 1);
          end
        end
      end
      REQ_DUMP: begin
        if (cnt == 0) begin
          expected_results.push_back(make_result(ST_EMPTY, '0, 1'b1));
        end else begin
          foreach (list_values[i])
            expected_results.push_back(make_result(ST_OK, list_values[i], i == cnt - 1));
        end
      end
      default: ;  // The unused request code gives no result.
    endcase
  endtask

  // Random values lean toward the extremes now and then so that every bit toggles.
  function automatic logic signed [31:0] random_value();
    case ($urandom_range(0, 5))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return -32'sd1;
      default: return $urandom();
    endcase
  endfunction

  task automatic queue_request(req_t op, logic signed [31:0] v, logic [5:0] pos);
    in_item_t r;
    r.req_type = op;
    r.value    = v;
    r.position = pos;
    pending_requests.push_back(r);
  endtask

  // Stimulus: a directed opening, then random requests whose mix drifts between
  // filling and draining so that both the full and the empty store are reached.
  initial begin
    int fill_bias;
    int op_pick;
    stimulus_done = 1'b0;
    queue_request(REQ_DUMP, 32'sd0, 6'd0);
    queue_request(REQ_DEL_FRONT, 32'sd0, 6'd0);
    queue_request(REQ_DEL_BACK, 32'sd0, 6'd0);
    queue_request(REQ_DEL_AT, 32'sd0, 6'd63);
    queue_request(REQ_INS_AT, 32'sd5, 6'd0);
    queue_request(REQ_INS_AT, 32'sd5, 6'd2);
    queue_request(REQ_INS_FRONT, 32'sh7fffffff, 6'd63);
    queue_request(REQ_INS_BACK, 32'sh80000000, 6'd0);
    queue_request(REQ_INS_AT, -32'sd1, 6'd2);
    queue_request(REQ_INS_AT, 32'sh55aa55aa, 6'd4);
    queue_request(REQ_INS_AT, 32'sh0, 6'd6);
    queue_request(REQ_NONE, 32'sh12345678, 6'd1);
    queue_request(REQ_DUMP, 32'sd0, 6'd0);
    queue_request(REQ_DEL_AT, 32'sd0, 6'd0);
    queue_request(REQ_DEL_AT, 32'sd0, 6'd5);
    queue_request(REQ_DEL_AT, 32'sd0, 6'd2);
    queue_request(REQ_DEL_AT, 32'sd0, 6'd3);
    queue_request(REQ_DEL_BACK, 32'sd0, 6'd0);
    queue_request(REQ_DEL_FRONT, 32'sd0, 6'd0);
    queue_request(REQ_DEL_FRONT, 32'sd0, 6'd0);
    queue_request(REQ_DUMP, 32'sd0, 6'd0);
    fill_bias = 80;
    for (int i = 0; i < 260; i++) begin
      if (i % 50 == 0) fill_bias = (fill_bias > 50) ? 20 : 85;
      op_pick = $urandom_range(0, 99);
      if (op_pick < 6)
        queue_request(REQ_DUMP, random_value(), 6'($urandom()));
      else if (op_pick < 8)
        queue_request(REQ_NONE, random_value(), 6'($urandom()));
      else if ($urandom_range(0, 99) < fill_bias)
        queue_request(req_t'($urandom_range(0, 2)), random_value(),
                      ($urandom_range(0, 9) == 0) ? 6'($urandom()) :
                      6'($urandom_range(1, 33)));
      else
        queue_request(req_t'($urandom_range(3, 5)), random_value(),
                      ($urandom_range(0, 9) == 0) ? 6'($urandom()) :
                      6'($urandom_range(1, 32)));
    end
    stimulus_done = 1'b1;
  end

  // Driver: sends pending transactions in bursts with random gaps. A request
  // stays on the port until the engine takes it with busy low.
  always @(posedge clk) begin
    if (!rst_n) begin
      start      <= 1'b0;
      in_item    <= '0;
      gap_left   <= 0;
      burst_left <= 0;
    end else if (start && !busy) begin
      predict_request(in_item);
      if (burst_left > 0 && pending_requests.size() > 0) begin
        in_item    <= pending_requests.pop_front();
        burst_left <= burst_left - 1;
      end else begin
        start    <= 1'b0;
        gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
      end
    end else if (!start) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
      end else if (pending_requests.size() > 0) begin
        start      <= 1'b1;
        in_item    <= pending_requests.pop_front();
        burst_left <= $urandom_range(0, 12);
      end
    end
  end

  // Monitor: every strobed result is compared with the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (expected_results.size() == 0) begin
        mismatch_count <= mismatch_count + 1;
        if (mismatch_count < 10)
          $display("unexpected result: status %0d value %0d last %0b",
                   out_item.status, out_item.item_value, out_item.last_item);
      end else begin
        out_item_t exp_r;
        exp_r = expected_results.pop_front();
        if (out_item !== exp_r) begin
          mismatch_count <= mismatch_count + 1;
          if (mismatch_count < 10)
            $display("mismatch: expected status %0d value %0d last %0b, got %0d %0d %0b",
                     exp_r.status, exp_r.item_value, exp_r.last_item,
                     out_item.status, out_item.item_value, out_item.last_item);
        end
      end
    end
  end

  // Timeout guard.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[doubly_linked_list_engine_unit] ERROR");
      $finish;
    end
  end

  initial begin
    mismatch_count = 0;
    cycle_count    = 0;
    rst_n          = 1'b0;
    start          = 1'b0;
    in_item        = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    wait (stimulus_done && pending_requests.size() == 0 && !start);
    while (expected_results.size() != 0) @(posedge clk);
    // Let any late result of the engine show up before the verdict.
    repeat (NODES + 10) @(posedge clk);
    if (mismatch_count == 0 && expected_results.size() == 0)
      $display("[doubly_linked_list_engine_unit] OK");
    else
      $display("[doubly_linked_list_engine_unit] ERROR");
    $finish;
  end

endmodule
